// ===== rtl/rfrb_pkg.sv =====
`default_nettype none

package rfrb_pkg;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] left;
        logic [7:0] top;
        logic [7:0] right;
        logic [7:0] bottom;
        logic [7:0] color;
        logic [7:0] table_index;
        logic [7:0] table_value;
    } cmd_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       done_res;
    } result_t;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 2'd2;

    localparam logic [3:0] MODE_FILL_RECT  = 4'd0;
    localparam logic [3:0] MODE_REMAP_RECT = 4'd1;
    localparam logic [3:0] MODE_FILL_ROW   = 4'd2;
    localparam logic [3:0] MODE_FILL_COL   = 4'd3;
    localparam logic [3:0] MODE_REMAP_ROW  = 4'd4;
    localparam logic [3:0] MODE_REMAP_COL  = 4'd5;
    localparam logic [3:0] MODE_OUTLINE    = 4'd6;
    localparam logic [3:0] MODE_LOAD_TABLE = 4'd7;
    localparam logic [3:0] MODE_READ_PIXEL = 4'd8;

    // register values above this act as this
    localparam logic [8:0] MAX_DIM   = 9'd128;
    localparam logic [7:0] DIM_RESET = 8'd128;

endpackage

`default_nettype wire

// ===== rtl/rect_fill_remap_blitter.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// command   in         start, busy            cmd (cmd_t)
// result    out        done (one-cycle pulse) result (result_t)
// config    in         cfg_valid, cfg_ready   cfg_index, cfg_data
//
// After reset a clearing pass writes zero to every pixel, with busy high.
// Fill: each piece is set up, then its pixels are written through the single write port.
// Remap: per pixel in the store a pixel read, table read and write; others are skipped.
// Outline runs as four pieces; a readpixel outside the store skips the read wait.
// done pulses in the first cycle with busy low; the receiver cannot stall it.
module rect_fill_remap_blitter #(
    parameter int STORE_BYTES = 16384
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire rfrb_pkg::cmd_t                 cmd,
    output logic                                done,
    output rfrb_pkg::result_t                   result,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rfrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data
);
    import rfrb_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    typedef logic signed [9:0]  coord_t;
    typedef logic signed [17:0] addr_t;

    localparam addr_t          STORE_LIM  = addr_t'(STORE_BYTES);
    localparam logic [AW-1:0]  CLEAR_LAST = AW'(STORE_BYTES - 1);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_SEG     = 3'd2;
    localparam logic [2:0] ST_WALK    = 3'd3;
    localparam logic [2:0] ST_RM_TBL  = 3'd4;
    localparam logic [2:0] ST_RM_WR   = 3'd5;
    localparam logic [2:0] ST_RP_WAIT = 3'd6;
    localparam logic [2:0] ST_MISC    = 3'd7;

    function automatic logic [7:0] sat_dim(input logic [7:0] v);
        return ({1'b0, v} > MAX_DIM) ? MAX_DIM[7:0] : v;
    endfunction

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          done_reg, done_next;
    logic [7:0]    pv_reg, pv_next;
    logic [7:0]    width_reg, height_reg, pitch_reg;

    cmd_t          cmd_reg, cmd_next;
    logic [1:0]    seg_reg, seg_next;
    coord_t        x_reg, x_next, y_reg, y_next;
    coord_t        seg_x0_reg, seg_x0_next, seg_x1_reg, seg_x1_next;
    coord_t        seg_y1_reg, seg_y1_next;
    addr_t         addr_reg, addr_next, row_addr_reg, row_addr_next;

    logic [7:0]    pix_mem [STORE_BYTES];
    logic [7:0]    tbl_mem [256];
    logic [7:0]    pix_rdata_reg, tbl_rdata_reg;
    logic          pix_we, tbl_we;
    logic [AW-1:0] pix_waddr;
    logic [7:0]    pix_wdata;

    coord_t        l_c, t_c, r_c, b_c, sx0, sx1, sy0, sy1;
    logic [7:0]    clip_r, clip_b;
    addr_t         prod_full;
    addr_t         start_addr, row_step;
    coord_t        x_inc, y_inc;
    logic [1:0]    seg_last;
    logic          is_remap, is_read, addr_ok, adv, seg_end;

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign cfg_ready = 1'b1;
    assign result.pixel_value = pv_reg;
    assign result.done_res    = 1'b1;

    // current piece of the command
    always_comb
    begin
        clip_r = (cmd_reg.right > width_reg) ? width_reg : cmd_reg.right;
        clip_b = (cmd_reg.bottom > height_reg) ? height_reg : cmd_reg.bottom;
        l_c = coord_t'({2'b00, cmd_reg.left});
        t_c = coord_t'({2'b00, cmd_reg.top});
        r_c = coord_t'({2'b00, cmd_reg.right});
        b_c = coord_t'({2'b00, cmd_reg.bottom});
        sx0 = l_c;
        sx1 = r_c;
        sy0 = t_c;
        sy1 = b_c;
        case (cmd_reg.mode)
            MODE_FILL_RECT:
            begin
                sx1 = coord_t'({2'b00, clip_r});
                sy1 = coord_t'({2'b00, clip_b});
            end
            MODE_FILL_ROW, MODE_REMAP_ROW:
            begin
                sy1 = t_c + 10'sd1;
            end
            MODE_FILL_COL, MODE_REMAP_COL:
            begin
                sx1 = l_c + 10'sd1;
            end
            MODE_OUTLINE:
            begin
                case (seg_reg)
                    2'd0:
                    begin
                        sy1 = t_c + 10'sd1;
                    end
                    2'd1:
                    begin
                        sx1 = r_c - 10'sd1;
                        sy0 = b_c - 10'sd1;
                    end
                    2'd2:
                    begin
                        sx1 = l_c + 10'sd1;
                    end
                    default:
                    begin
                        sx0 = r_c - 10'sd1;
                    end
                endcase
            end
            MODE_READ_PIXEL:
            begin
                sx1 = l_c + 10'sd1;
                sy1 = t_c + 10'sd1;
            end
            default:
            begin
            end
        endcase
    end

    assign prod_full  = addr_t'(sy0) * addr_t'($signed({1'b0, pitch_reg}));
    assign start_addr = prod_full + addr_t'(sx0);
    assign row_step   = row_addr_reg + addr_t'({1'b0, pitch_reg});
    assign x_inc      = x_reg + 10'sd1;
    assign y_inc      = y_reg + 10'sd1;
    assign seg_last   = (cmd_reg.mode == MODE_OUTLINE) ? 2'd3 : 2'd0;
    assign is_remap   = cmd_reg.mode inside {MODE_REMAP_RECT, MODE_REMAP_ROW, MODE_REMAP_COL};
    assign is_read    = (cmd_reg.mode == MODE_READ_PIXEL);
    assign addr_ok    = !addr_reg[17] && (addr_reg < STORE_LIM);

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        done_next     = 1'b0;
        pv_next       = pv_reg;
        cmd_next      = cmd_reg;
        seg_next      = seg_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        seg_x0_next   = seg_x0_reg;
        seg_x1_next   = seg_x1_reg;
        seg_y1_next   = seg_y1_reg;
        addr_next     = addr_reg;
        row_addr_next = row_addr_reg;
        pix_we        = 1'b0;
        pix_waddr     = addr_reg[AW-1:0];
        pix_wdata     = cmd_reg.color;
        tbl_we        = 1'b0;
        adv           = 1'b0;
        seg_end       = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                pix_we    = 1'b1;
                pix_waddr = clr_cnt_reg;
                pix_wdata = 8'd0;
                if (clr_cnt_reg == CLEAR_LAST)
                    state_next = ST_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    seg_next = 2'd0;
                    if (cmd.mode inside {[MODE_FILL_RECT:MODE_OUTLINE], MODE_READ_PIXEL})
                        state_next = ST_SEG;
                    else
                        state_next = ST_MISC;
                end
            end
            ST_SEG:
            begin
                seg_x0_next   = sx0;
                seg_x1_next   = sx1;
                seg_y1_next   = sy1;
                x_next        = sx0;
                y_next        = sy0;
                addr_next     = start_addr;
                row_addr_next = start_addr;
                if (sx1 <= sx0 || sy1 <= sy0)
                    seg_end = 1'b1;
                else
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (is_read)
                begin
                    if (addr_ok)
                        state_next = ST_RP_WAIT;
                    else
                    begin
                        done_next  = 1'b1;
                        pv_next    = 8'd0;
                        state_next = ST_IDLE;
                    end
                end
                else if (is_remap)
                begin
                    if (addr_ok)
                        state_next = ST_RM_TBL;
                    else
                        adv = 1'b1;
                end
                else
                begin
                    pix_we = addr_ok;
                    adv    = 1'b1;
                end
            end
            ST_RM_TBL:
            begin
                // table read of the fetched pixel is under way
                state_next = ST_RM_WR;
            end
            ST_RM_WR:
            begin
                pix_we     = 1'b1;
                pix_wdata  = tbl_rdata_reg;
                state_next = ST_WALK;
                adv        = 1'b1;
            end
            ST_RP_WAIT:
            begin
                done_next  = 1'b1;
                pv_next    = pix_rdata_reg;
                state_next = ST_IDLE;
            end
            ST_MISC:
            begin
                tbl_we     = (cmd_reg.mode == MODE_LOAD_TABLE);
                done_next  = 1'b1;
                pv_next    = 8'd0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // advance to the next pixel, row or piece
        if (adv)
        begin
            if (x_inc < seg_x1_reg)
            begin
                x_next    = x_inc;
                addr_next = addr_reg + 18'sd1;
            end
            else if (y_inc < seg_y1_reg)
            begin
                x_next        = seg_x0_reg;
                y_next        = y_inc;
                row_addr_next = row_step;
                addr_next     = row_step;
            end
            else
                seg_end = 1'b1;
        end

        if (seg_end)
        begin
            if (seg_reg == seg_last)
            begin
                done_next  = 1'b1;
                pv_next    = 8'd0;
                state_next = ST_IDLE;
            end
            else
            begin
                seg_next   = seg_reg + 2'd1;
                state_next = ST_SEG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            pitch_reg  <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= sat_dim(cfg_data);
                CFG_HEIGHT: height_reg <= sat_dim(cfg_data);
                CFG_PITCH:  pitch_reg  <= sat_dim(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        pv_reg       <= pv_next;
        cmd_reg      <= cmd_next;
        seg_reg      <= seg_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        seg_x0_reg   <= seg_x0_next;
        seg_x1_reg   <= seg_x1_next;
        seg_y1_reg   <= seg_y1_next;
        addr_reg     <= addr_next;
        row_addr_reg <= row_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[pix_waddr] <= pix_wdata;
        pix_rdata_reg <= pix_mem[addr_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[cmd_reg.table_index] <= cmd_reg.table_value;
        tbl_rdata_reg <= tbl_mem[pix_rdata_reg];
    end

endmodule

`default_nettype wire

// ===== rtl/rfrb_checker.sv =====
`default_nettype none

module rfrb_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic              done,
    input  wire rfrb_pkg::result_t result
);
    logic accept;

    assign accept = start && !busy;

    // a finished command leaves the block free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done shown while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted request did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !done)
        else $error("result in the cycle right after a request");

    a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.done_res)
        else $error("result shown without its completion flag");

endmodule

bind rect_fill_remap_blitter rfrb_checker u_rfrb_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

import rfrb_pkg::*;

class surface_model;
    localparam int STORE_BYTES = 16384;

    bit [7:0]  pixels [STORE_BYTES];
    bit [7:0]  pixels_saved [STORE_BYTES];
    bit [7:0]  remap [256];
    bit        loaded [256];
    int        width;
    int        height;
    int        pitch;
    int        missing;
    int        mismatches;
    result_t   due_results [$];

    function new();
        foreach (pixels[i]) pixels[i] = 8'h00;
        foreach (loaded[i])
        begin
            loaded[i] = 1'b0;
            remap[i]  = 8'h00;
        end
        width      = sat_dim(DIM_RESET);
        height     = sat_dim(DIM_RESET);
        pitch      = sat_dim(DIM_RESET);
        missing    = -1;
        mismatches = 0;
    endfunction

    function int sat_dim(logic [7:0] v);
        return (v > MAX_DIM) ? int'(MAX_DIM) : int'(v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        case (idx)
            CFG_WIDTH:  width  = sat_dim(value);
            CFG_HEIGHT: height = sat_dim(value);
            CFG_PITCH:  pitch  = sat_dim(value);
            default: ;
        endcase
    endfunction

    function void put(int x, int y, bit do_remap, logic [7:0] color);
        int a;
        a = x + y * pitch;
        if (a < 0 || a >= STORE_BYTES)
            return;
        if (do_remap)
        begin
            if (!loaded[pixels[a]] && missing < 0)
                missing = pixels[a];
            pixels[a] = remap[pixels[a]];
        end
        else
        begin
            pixels[a] = color;
        end
    endfunction

    // rows and columns are rectangles one pixel thick
    function void paint(int x0, int y0, int x1, int y1, bit do_remap, logic [7:0] color);
        for (int y = y0; y < y1; y++)
            for (int x = x0; x < x1; x++)
                put(x, y, do_remap, color);
    endfunction

    function logic [7:0] apply(cmd_t c);
        int         l;
        int         t;
        int         r;
        int         b;
        int         a;
        logic [7:0] pv;
        l  = c.left;
        t  = c.top;
        r  = c.right;
        b  = c.bottom;
        pv = 8'h00;
        case (c.mode)
            MODE_FILL_RECT:
            begin
                if (b > height) b = height;
                if (r > width)  r = width;
                paint(l, t, r, b, 1'b0, c.color);
            end
            MODE_REMAP_RECT: paint(l, t, r, b, 1'b1, 8'h00);
            MODE_FILL_ROW:   paint(l, t, r, t + 1, 1'b0, c.color);
            MODE_FILL_COL:   paint(l, t, l + 1, b, 1'b0, c.color);
            MODE_REMAP_ROW:  paint(l, t, r, t + 1, 1'b1, 8'h00);
            MODE_REMAP_COL:  paint(l, t, l + 1, b, 1'b1, 8'h00);
            MODE_OUTLINE:
            begin
                paint(l, t, r, t + 1, 1'b0, c.color);
                paint(l, b - 1, r - 1, b, 1'b0, c.color);
                paint(l, t, l + 1, b, 1'b0, c.color);
                paint(r - 1, t, r, b, 1'b0, c.color);
            end
            MODE_LOAD_TABLE:
            begin
                remap[c.table_index]  = c.table_value;
                loaded[c.table_index] = 1'b1;
            end
            MODE_READ_PIXEL:
            begin
                a = l + t * pitch;
                if (a >= 0 && a < STORE_BYTES)
                    pv = pixels[a];
            end
            default: ;
        endcase
        return pv;
    endfunction

    // dry run: first table entry the command would read before it is loaded
    function int first_unloaded(cmd_t c);
        pixels_saved = pixels;
        missing      = -1;
        void'(apply(c));
        pixels       = pixels_saved;
        return missing;
    endfunction

    function void note_cmd(cmd_t c);
        result_t e;
        e.pixel_value = apply(c);
        e.done_res    = 1'b1;
        due_results.push_back(e);
    endfunction

    function void check_result(result_t got);
        result_t e;
        if (due_results.size() == 0)
        begin
            $error("result with no command outstanding: pixel_value %0h done_res %0b",
                   got.pixel_value, got.done_res);
            mismatches++;
            return;
        end
        e = due_results.pop_front();
        if (got.pixel_value !== e.pixel_value)
        begin
            $error("pixel_value: expected %0h, got %0h", e.pixel_value, got.pixel_value);
            mismatches++;
        end
        if (got.done_res !== e.done_res)
        begin
            $error("done_res: expected %0b, got %0b", e.done_res, got.done_res);
            mismatches++;
        end
    endfunction

    function int outstanding();
        return due_results.size();
    endfunction
endclass

module tb;
    localparam int STALL_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int ITEMS_PER_PHASE = 62;
    localparam int PHASES          = 9;
    localparam int MAX_COORD       = 128;
    localparam int SHORT_SPAN      = 12;

    localparam logic [3:0]           MODE_UNUSED_FIRST = 4'd9;
    localparam logic [3:0]           MODE_UNUSED_LAST  = 4'd15;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE         = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cmd_t                 cmd;
    logic                 done;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    surface_model model;
    int           idle_pct;
    int           stall_cycles;
    int           issued;
    int           last_x;
    int           last_y;

    rect_fill_remap_blitter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            model.check_result(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [7:0] rnd8(int lo, int hi);
        int v;
        v = $urandom_range(hi, lo);
        return v[7:0];
    endfunction

    function automatic logic [7:0] near(int origin, int reach);
        int v;
        v = origin + $urandom_range(reach, 0);
        if (v > MAX_COORD)
            v = MAX_COORD;
        return v[7:0];
    endfunction

    // mostly short spans, a few empty or reversed ones, rarely the full range
    function automatic logic [7:0] span_end(logic [7:0] s, bit wide);
        int e;
        if (wide)
            e = $urandom_range(MAX_COORD, 0);
        else if ($urandom_range(9, 0) == 0)
            e = $urandom_range(s, 0);
        else
            e = s + $urandom_range(SHORT_SPAN, 1);
        if (e > MAX_COORD)
            e = MAX_COORD;
        return e[7:0];
    endfunction

    function automatic cmd_t make_cmd(logic [3:0] mode, logic [7:0] l, logic [7:0] t,
                                      logic [7:0] r, logic [7:0] b, logic [7:0] color);
        cmd_t c;
        c.mode        = mode;
        c.left        = l;
        c.top         = t;
        c.right       = r;
        c.bottom      = b;
        c.color       = color;
        c.table_index = rnd8(0, 255);
        c.table_value = rnd8(0, 255);
        return c;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   pick;
        int   m;
        bit   wide;
        c = make_cmd(MODE_READ_PIXEL, rnd8(0, MAX_COORD), rnd8(0, MAX_COORD), 8'h00, 8'h00,
                     rnd8(0, 255));
        wide = ($urandom_range(99, 0) < 5);
        pick = $urandom_range(99, 0);
        if (pick < 30)
        begin
            // aim most reads at the area written last
            if (pick < 22)
            begin
                c.left = near(last_x, 6);
                c.top  = near(last_y, 3);
            end
        end
        else if (pick < 38)
        begin
            c.mode = MODE_LOAD_TABLE;
        end
        else if (pick < 41)
        begin
            m      = $urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST);
            c.mode = m[3:0];
        end
        else
        begin
            m      = $urandom_range(MODE_OUTLINE, MODE_FILL_RECT);
            c.mode = m[3:0];
            last_x = c.left;
            last_y = c.top;
        end
        c.right  = span_end(c.left, wide);
        c.bottom = span_end(c.top, wide);
        return c;
    endfunction

    // leaves start high; the next request or a drain lowers it
    task automatic send_cmd(cmd_t c);
        if ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < idle_pct);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        model.note_cmd(c);
        issued++;
    endtask

    task automatic load_entry(logic [7:0] idx, logic [7:0] value);
        cmd_t c;
        c             = make_cmd(MODE_LOAD_TABLE, rnd8(0, MAX_COORD), rnd8(0, MAX_COORD),
                                 rnd8(0, MAX_COORD), rnd8(0, MAX_COORD), rnd8(0, 255));
        c.table_index = idx;
        c.table_value = value;
        send_cmd(c);
    endtask

    // load every table entry a remap would touch before sending it
    task automatic run_cmd(cmd_t c);
        int need;
        if (c.mode inside {MODE_REMAP_RECT, MODE_REMAP_ROW, MODE_REMAP_COL})
        begin
            need = model.first_unloaded(c);
            while (need >= 0)
            begin
                load_entry(need[7:0], rnd8(0, 255));
                need = model.first_unloaded(c);
            end
        end
        send_cmd(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (model.outstanding() > 0);
    endtask

    // leaves cfg_valid high; configure lowers it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        model.write_reg(idx, value);
    endtask

    task automatic configure(logic [7:0] w, logic [7:0] h, logic [7:0] p);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_PITCH, p);
        cfg_valid <= 1'b0;
    endtask

    task automatic phase_config(int ph);
        case (ph)
            0:
            begin
                write_reg(CFG_SPARE, rnd8(0, 255));
                configure(8'd128, 8'd128, 8'd128);
            end
            1: configure(8'd1, 8'd1, 8'd1);
            2: configure(8'd0, 8'd0, 8'd0);
            3: configure(8'd255, 8'd129, 8'd200);
            4: configure(rnd8(1, 128), rnd8(1, 128), rnd8(1, 128));
            5: configure(8'd128, 8'd128, 8'd1);
            6: configure(8'd1, 8'd128, 8'd128);
            7: configure(rnd8(0, 255), rnd8(0, 255), rnd8(0, 255));
            default: configure(8'd128, 8'd128, 8'd128);
        endcase
    endtask

    task automatic run_directed();
        run_cmd(make_cmd(MODE_READ_PIXEL, 0, 0, 0, 0, 8'h00));
        load_entry(8'h00, 8'hA5);
        load_entry(8'hFF, 8'h5A);
        run_cmd(make_cmd(MODE_FILL_RECT, 0, 0, 128, 128, 8'hFF));
        run_cmd(make_cmd(MODE_READ_PIXEL, 127, 127, 0, 0, 8'h00));
        // one past the last byte of the store
        run_cmd(make_cmd(MODE_READ_PIXEL, 128, 127, 0, 0, 8'h00));
        run_cmd(make_cmd(MODE_REMAP_RECT, 0, 0, 128, 128, 8'h00));
        run_cmd(make_cmd(MODE_READ_PIXEL, 64, 64, 0, 0, 8'h00));
        // reversed and zero-length spans write nothing
        run_cmd(make_cmd(MODE_FILL_RECT, 20, 10, 5, 30, 8'h11));
        run_cmd(make_cmd(MODE_FILL_ROW, 3, 2, 3, 0, 8'h22));
        run_cmd(make_cmd(MODE_FILL_ROW, 0, 128, 10, 0, 8'h33));
        run_cmd(make_cmd(MODE_FILL_ROW, 0, 5, 128, 0, 8'h00));
        run_cmd(make_cmd(MODE_FILL_COL, 128, 0, 0, 128, 8'h80));
        run_cmd(make_cmd(MODE_REMAP_ROW, 0, 5, 128, 0, 8'h00));
        run_cmd(make_cmd(MODE_REMAP_COL, 0, 0, 0, 128, 8'h00));
        run_cmd(make_cmd(MODE_READ_PIXEL, 0, 5, 0, 0, 8'h00));
        run_cmd(make_cmd(MODE_OUTLINE, 0, 0, 128, 128, 8'h3C));
        // right edge column at x = -1 wraps into the previous row
        run_cmd(make_cmd(MODE_OUTLINE, 0, 0, 0, 4, 8'hC3));
        // bottom edge row at y = -1 falls below the store
        run_cmd(make_cmd(MODE_OUTLINE, 0, 0, 3, 0, 8'h99));
        run_cmd(make_cmd(MODE_READ_PIXEL, 127, 0, 0, 0, 8'h00));
        run_cmd(make_cmd(MODE_READ_PIXEL, 0, 3, 0, 0, 8'h00));
        run_cmd(make_cmd(MODE_UNUSED_FIRST, 1, 1, 9, 9, 8'h44));
        run_cmd(make_cmd(MODE_UNUSED_LAST, 2, 2, 8, 8, 8'h55));
        run_cmd(make_cmd(MODE_READ_PIXEL, 1, 127, 0, 0, 8'h00));
    endtask

    initial
    begin
        int stop_at;
        model        = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_pct     = 0;
        issued       = 0;
        last_x       = 0;
        last_y       = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // hold off until the clearing pass is over
        @(posedge clk);
        while (busy)
            @(posedge clk);

        idle_pct = 11;
        run_directed();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 3)
                idle_pct = 11;
            else if (ph < 6)
                idle_pct = 81;
            else
                idle_pct = 0;
            drain();
            phase_config(ph);
            stop_at = issued + ITEMS_PER_PHASE;
            while (issued < stop_at)
            begin
                if ($urandom_range(39, 0) == 0)
                    drain();
                run_cmd(rand_cmd());
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (model.mismatches == 0 && model.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
